// ----- sv/rlte_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rlte_pkg
// Shared types, character codes and decimal helpers for the run-length
// text encoder.
// ----------------------------------------------------------------------------
package rlte_pkg;

   // Default width of the run counter and depth of the run queue
   localparam int DEFAULT_COUNT_BITS = 16;
   localparam int DEFAULT_QUEUE_DEPTH = 2;

   // Widest run counter the encoder supports
   localparam int LEN_MAX_BITS = 16;

   // Decimal digit places of the widest counter
   localparam int NUM_DIGITS = 5;
   localparam int POS_BITS = $clog2(NUM_DIGITS);

   // Character codes of the compressed text
   localparam logic [7:0] CHAR_OPEN = 8'h28;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;
   localparam logic [7:0] CHAR_ZERO = 8'h30;

   // Powers of ten, one per digit place
   localparam logic [16:0] POW10 [NUM_DIGITS] = '{
      17'd1, 17'd10, 17'd100, 17'd1000, 17'd10000
   };

   // Request and response payloads
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       item_done;
      logic       string_done;
   } rsp_type;

   // Run queue status seen by both ends
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Place of the leading digit of a nonzero value
   function automatic logic [POS_BITS-1:0] top_pos(input logic [LEN_MAX_BITS-1:0] v);
      logic [POS_BITS-1:0] p;
      p = '0;
      for (int k = 1; k < NUM_DIGITS; k++) begin
         if ({1'b0, v} >= POW10[k]) begin
            p = POS_BITS'(k);
         end
      end
      return p;
   endfunction

   // Decimal digit of v at place pos, given v below ten times that place
   function automatic logic [3:0] digit_at(input logic [LEN_MAX_BITS-1:0] v,
                                           input logic [POS_BITS-1:0] pos);
      logic [3:0] d;
      d = '0;
      for (int k = 1; k < 10; k++) begin
         if (32'({1'b0, v}) >= 32'(k) * 32'(POW10[pos])) begin
            d = 4'(k);
         end
      end
      return d;
   endfunction

   // Remainder after taking off the digit at place pos
   function automatic logic [LEN_MAX_BITS-1:0] digit_rest(input logic [LEN_MAX_BITS-1:0] v,
                                                          input logic [POS_BITS-1:0] pos);
      logic [3:0] d;
      d = digit_at(v, pos);
      return LEN_MAX_BITS'(32'(v) - 32'(d) * 32'(POW10[pos]));
   endfunction

endpackage
`default_nettype wire

// ----- sv/rlte_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rlte_front
// Accepts request bytes, tracks the open run and queues every run that
// closes, up to two per request.
// ----------------------------------------------------------------------------
module rlte_front import rlte_pkg::*; #(
   parameter int LEN_BITS = LEN_MAX_BITS,
   parameter int ENTRY_BITS = 2 * (8 + LEN_BITS) + 2
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   output logic                  full,
   input  req_type               req_data,
   input  queue_status_type      q_status,
   output logic                  q_wr,
   output logic [ENTRY_BITS-1:0] q_data
);

   typedef struct packed {
      logic                last;
      logic                has_b;
      logic [7:0]          char_b;
      logic [LEN_BITS-1:0] len_b;
      logic [7:0]          char_a;
      logic [LEN_BITS-1:0] len_a;
   } entry_type;

   localparam logic [LEN_BITS-1:0] MAX_COUNT = {LEN_BITS{1'b1}};

   logic [7:0]          run_char_ff, run_char_in;
   logic [LEN_BITS-1:0] run_len_ff, run_len_in;
   logic                run_open_ff, run_open_in;

   logic                accept;
   logic                same;
   logic [LEN_BITS-1:0] len_new;
   logic                close_now;
   entry_type           entry;

   assign full = q_status.full;
   assign accept = push && !q_status.full;

   // Extend the open run or start a new one, and close runs that end
   always_comb begin
      same = run_open_ff && (req_data.in_byte == run_char_ff);
      len_new = same ? (run_len_ff + LEN_BITS'(1)) : LEN_BITS'(1);
      close_now = (len_new == MAX_COUNT) || req_data.in_last;

      entry = '0;
      entry.last = req_data.in_last;
      if (!same && run_open_ff) begin
         entry.char_a = run_char_ff;
         entry.len_a = run_len_ff;
         entry.has_b = close_now;
         entry.char_b = req_data.in_byte;
         entry.len_b = LEN_BITS'(1);
      end else begin
         entry.char_a = req_data.in_byte;
         entry.len_a = len_new;
      end

      q_wr = accept && ((!same && run_open_ff) || close_now);
      q_data = entry;

      run_char_in = run_char_ff;
      run_len_in = run_len_ff;
      run_open_in = run_open_ff;
      if (accept) begin
         run_char_in = req_data.in_byte;
         run_len_in = close_now ? '0 : len_new;
         run_open_in = !close_now;
      end
   end

   // Hold the run state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_char_ff <= '0;
         run_len_ff <= '0;
         run_open_ff <= 1'b0;
      end else begin
         run_char_ff <= run_char_in;
         run_len_ff <= run_len_in;
         run_open_ff <= run_open_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/rlte_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rlte_queue
// Short queue of closed runs between the front and the back.
// ----------------------------------------------------------------------------
module rlte_queue import rlte_pkg::*; #(
   parameter int DEPTH = DEFAULT_QUEUE_DEPTH,
   parameter int WIDTH = 2 * (8 + LEN_MAX_BITS) + 2
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               wr_en,
   input  wire  [WIDTH-1:0]  wr_data,
   input  wire               rd_en,
   output logic [WIDTH-1:0]  rd_data,
   output queue_status_type  status
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_wr, do_rd;

   assign status.full = (count_ff == CNT_BITS'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign rd_data = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      do_wr = wr_en && !status.full;
      do_rd = rd_en && !status.empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      count_in = count_ff + CNT_BITS'(do_wr) - CNT_BITS'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Store the written run
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("run queue count beyond depth");

   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && status.full))
      else $error("run queue written while full");

endmodule
`default_nettype wire

// ----- sv/rlte_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rlte_back
// Takes closed runs from the queue and spells each out into the response
// register, one byte a cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module rlte_back import rlte_pkg::*; #(
   parameter int LEN_BITS = LEN_MAX_BITS,
   parameter int ENTRY_BITS = 2 * (8 + LEN_BITS) + 2
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire  [ENTRY_BITS-1:0] q_data,
   input  queue_status_type      q_status,
   output logic                  q_rd,
   output rsp_type               rsp_data,
   output logic                  empty,
   input  wire                   pop
);

   typedef struct packed {
      logic                last;
      logic                has_b;
      logic [7:0]          char_b;
      logic [LEN_BITS-1:0] len_b;
      logic [7:0]          char_a;
      logic [LEN_BITS-1:0] len_a;
   } entry_type;

   typedef enum logic [2:0] {
      P_IDLE,
      P_CHAR,
      P_OPEN,
      P_DIGIT,
      P_CLOSE
   } phase_type;

   phase_type           phase_ff, phase_in;
   entry_type           entry_ff, entry_in;
   logic                sel_ff, sel_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [LEN_BITS-1:0] rem_ff, rem_in;
   rsp_type             out_ff, out_in;
   logic                out_valid_ff, out_valid_in;

   logic                    out_free;
   logic                    load;
   logic                    run_done;
   logic [7:0]              cur_char;
   logic [LEN_BITS-1:0]     cur_len;
   logic [LEN_MAX_BITS-1:0] rem_wide;

   assign empty = !out_valid_ff;
   assign rsp_data = out_ff;
   assign q_rd = load && !q_status.empty;

   // Step through character, bracket, digits and bracket of the current run (only the character for a run of one)
   always_comb begin
      out_free = !out_valid_ff || pop;
      cur_char = sel_ff ? entry_ff.char_b : entry_ff.char_a;
      cur_len = sel_ff ? entry_ff.len_b : entry_ff.len_a;
      rem_wide = LEN_MAX_BITS'(rem_ff);

      phase_in = phase_ff;
      entry_in = entry_ff;
      sel_in = sel_ff;
      pos_in = pos_ff;
      rem_in = rem_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff && !pop;
      load = 1'b0;
      run_done = 1'b0;

      if (phase_ff == P_IDLE) begin
         load = 1'b1;
      end else if (out_free) begin
         out_valid_in = 1'b1;
         out_in.item_done = 1'b0;
         out_in.string_done = 1'b0;
         case (phase_ff)
            P_CHAR: begin
               out_in.out_byte = cur_char;
               if (cur_len > LEN_BITS'(1)) begin
                  phase_in = P_OPEN;
               end else begin
                  run_done = 1'b1;
               end
            end
            P_OPEN: begin
               out_in.out_byte = CHAR_OPEN;
               phase_in = P_DIGIT;
               pos_in = top_pos(LEN_MAX_BITS'(cur_len));
               rem_in = cur_len;
            end
            P_DIGIT: begin
               out_in.out_byte = CHAR_ZERO + 8'(digit_at(rem_wide, pos_ff));
               rem_in = LEN_BITS'(digit_rest(rem_wide, pos_ff));
               if (pos_ff == '0) begin
                  phase_in = P_CLOSE;
               end else begin
                  pos_in = pos_ff - POS_BITS'(1);
               end
            end
            P_CLOSE: begin
               out_in.out_byte = CHAR_CLOSE;
               run_done = 1'b1;
            end
            default: begin
               out_valid_in = out_valid_ff && !pop;
               phase_in = P_IDLE;
            end
         endcase

         // Move to the second run or finish the request
         if (run_done) begin
            if (!sel_ff && entry_ff.has_b) begin
               sel_in = 1'b1;
               phase_in = P_CHAR;
            end else begin
               out_in.item_done = 1'b1;
               out_in.string_done = entry_ff.last;
               phase_in = P_IDLE;
               load = 1'b1;
            end
         end
      end

      // Fetch the next queued request
      if (load && !q_status.empty) begin
         entry_in = q_data;
         sel_in = 1'b0;
         phase_in = P_CHAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         out_valid_ff <= out_valid_in;
      end
      entry_ff <= entry_in;
      sel_ff <= sel_in;
      pos_ff <= pos_in;
      rem_ff <= rem_in;
      out_ff <= out_in;
   end

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == P_DIGIT) |-> (32'(rem_ff) < 32'd10 * 32'(POW10[pos_ff])))
      else $error("remainder too large for digit place");

endmodule
`default_nettype wire

// ----- sv/run_length_text_encoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// run_length_text_encoder
// Run-length encoder for text: a run of one byte is passed through, a longer
// run becomes the byte, '(', its decimal length and ')'.
// ----------------------------------------------------------------------------
// A request is taken every cycle while the run queue has room; requests that
// close no run cost nothing downstream. The back end spells out one response
// byte per cycle from its output register while that register is empty or
// being popped. A closed run of length 1 gives one byte, a longer run gives 3
// plus its digit count, and a request that closes two runs gives the sum of both.
// After the back end has gone idle, the first queued run is fetched in its
// idle state before its first byte is spelled. Full rises when the
// QUEUE_DEPTH-entry run queue fills. Runs are capped at 2^COUNT_BITS - 1 bytes
// (COUNT_BITS clamped to 2..16); a run reaching the cap is flushed at once.
module run_length_text_encoder import rlte_pkg::*; #(
   parameter int COUNT_BITS = DEFAULT_COUNT_BITS,
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  wire      clock,
   input  wire      reset,
   input  wire      push,
   output logic     full,
   input  req_type  req_data,
   output logic     empty,
   input  wire      pop,
   output rsp_type  rsp_data
);

   localparam int LEN_BITS = (COUNT_BITS < 2) ? 2 :
                             ((COUNT_BITS > LEN_MAX_BITS) ? LEN_MAX_BITS : COUNT_BITS);
   localparam int ENTRY_BITS = 2 * (8 + LEN_BITS) + 2;

   queue_status_type      q_status;
   logic                  q_wr;
   logic                  q_rd;
   logic [ENTRY_BITS-1:0] q_wr_data;
   logic [ENTRY_BITS-1:0] q_rd_data;

   // Classify requests and queue closed runs
   rlte_front #(
      .LEN_BITS   (LEN_BITS),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_status (q_status),
      .q_wr     (q_wr),
      .q_data   (q_wr_data)
   );

   rlte_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (ENTRY_BITS)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_wr),
      .wr_data (q_wr_data),
      .rd_en   (q_rd),
      .rd_data (q_rd_data),
      .status  (q_status)
   );

   // Spell out runs into responses
   rlte_back #(
      .LEN_BITS   (LEN_BITS),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_data   (q_rd_data),
      .q_status (q_status),
      .q_rd     (q_rd),
      .rsp_data (rsp_data),
      .empty    (empty),
      .pop      (pop)
   );

   a_string_end: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.string_done) |-> rsp_data.item_done)
      else $error("string end without request end");

endmodule
`default_nettype wire
